[rtl/core/packet_timestamp_gap_tracker_defines.svh]
// Assertion helpers for the tracker back-end RTL
`ifndef PACKET_TIMESTAMP_GAP_TRACKER_DEFINES_SVH
`define PACKET_TIMESTAMP_GAP_TRACKER_DEFINES_SVH

// Condition that holds at every edge outside reset
`define PTGT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define PTGT_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[rtl/core/ptgt_pkg.sv]
package ptgt_pkg;

   localparam int REG_W         = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int STAMP_W       = 64;
   localparam int CNT_W         = 32;
   localparam int FILL_W        = 16;
   localparam int IDX_W         = 8;
   localparam int PERIOD_W      = 24;
   localparam int BSIZE_W       = 9;
   localparam int DIV_D_W       = 24;
   localparam int DIV_N_W       = STAMP_W + 8;
   localparam int DIV_BITS      = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int MAX_BATCH_DEF = 256;
   localparam int REQ_TDATA_W   = 104;
   localparam int RSP_TDATA_W   = 256;

   typedef enum logic [2:0] {
      ST_INVALID      = 3'd0,
      ST_FIRST        = 3'd1,
      ST_DUPLICATE    = 3'd2,
      ST_OUT_OF_ORDER = 3'd3,
      ST_IN_ORDER     = 3'd4,
      ST_GAP          = 3'd5
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAP_THRESHOLD = 3'd0,
      CSR_PERIOD        = 3'd1,
      CSR_TRIG_ENABLE   = 3'd2,
      CSR_TRIG_BIT      = 3'd3,
      CSR_BATCH_LEN     = 3'd4,
      CSR_FILL_MODE     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      FILL_NONE        = 2'd0,
      FILL_ASAP        = 2'd1,
      FILL_DISTRIBUTED = 2'd2
   } fill_mode_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MISS_DIV,
      BK_MISS_SUM,
      BK_BATCH,
      BK_LAG_SEL,
      BK_LAG_DIV,
      BK_FILL_MUL,
      BK_FILL_ADD,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic [REG_W-1:0]    gap_threshold;
      logic [PERIOD_W-1:0] period;
      logic                trig_enable;
      logic [4:0]          trig_bit;
      logic [BSIZE_W-1:0]  batch_len;
      logic [1:0]          fill_mode;
   } cfg_type;

   typedef struct packed {
      status_type          status;
      logic [STAMP_W-1:0]  delta;
      logic [STAMP_W-1:0]  stamp;
      logic                dispatch;
      logic [CNT_W-1:0]    invalid_total;
      logic [CNT_W-1:0]    duplicate_total;
      logic [CNT_W-1:0]    out_of_order_total;
      logic [CNT_W-1:0]    gap_total;
   } job_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quot;
      logic [DIV_D_W-1:0] rem;
   } div_rsp_type;

endpackage

[rtl/core/packet_timestamp_gap_tracker.sv]
// With no gap and no fill a request goes through the idle, batch and output states; a gap
// adds a 72-bit quotient at 2 bits per cycle in the shared divider and a sum step, a fill
// a lag select, multiply and add step, with a second division between them for asap fill.
// The back end takes one request at a time and holds it through any result stall; a
// 2-entry queue lets the front take requests meanwhile. Synchronous active-high reset
// clears counters, timestamps, trigger, batch state and loads register defaults.
module packet_timestamp_gap_tracker #(
   parameter int MAX_BATCH = ptgt_pkg::MAX_BATCH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // record_valid[0], stamp[64:1], ttl_word[96:65], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ptgt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // status, missed_now, emit_sample, sample_index, batch_start, batch_end,
   // fill_batches, stamp_out, invalid_total, duplicate_total,
   // out_of_order_total, gap_total, zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ptgt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [ptgt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ptgt_pkg::REG_W-1:0]        csr_wdata
);
   import ptgt_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_empty, q_push, q_pop;
   job_type push_job, pop_job;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_GAP_THRESHOLD: cfg_in.gap_threshold = csr_wdata;
            CSR_PERIOD:        cfg_in.period        = csr_wdata[PERIOD_W-1:0];
            CSR_TRIG_ENABLE:   cfg_in.trig_enable   = csr_wdata[0];
            CSR_TRIG_BIT:      cfg_in.trig_bit      = csr_wdata[4:0];
            CSR_BATCH_LEN:     cfg_in.batch_len     = csr_wdata[BSIZE_W-1:0];
            CSR_FILL_MODE:     cfg_in.fill_mode     = csr_wdata[1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_threshold <= REG_W'(40);
         cfg_ff.period        <= PERIOD_W'(8000);
         cfg_ff.trig_enable   <= 1'b0;
         cfg_ff.trig_bit      <= '0;
         cfg_ff.batch_len     <= BSIZE_W'(1);
         cfg_ff.fill_mode     <= FILL_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptgt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   ptgt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   ptgt_back #(
      .MAX_BATCH (MAX_BATCH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_job      (pop_job),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/ptgt_div.sv]
module ptgt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ptgt_pkg::div_req_type div_req,
   output ptgt_pkg::div_rsp_type div_rsp
);
   import ptgt_pkg::*;

   localparam int STEPS = DIV_N_W / DIV_BITS;
   localparam int CW    = $clog2(STEPS + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] dq_ff, dq_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] dvs_ff, dvs_in;
   logic [DIV_D_W:0]   trial;

   // Restoring division, two quotient bits per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = '0;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(STEPS);
         dq_in   = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         for (int j = 0; j < DIV_BITS; j++) begin
            trial = {rem_in, dq_in[DIV_N_W-1]};
            dq_in = {dq_in[DIV_N_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in   = DIV_D_W'(trial - {1'b0, dvs_ff});
               dq_in[0] = 1'b1;
            end else begin
               rem_in = trial[DIV_D_W-1:0];
            end
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = dq_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

[rtl/core/ptgt_front.sv]
module ptgt_front (
   input  logic                               clock,
   input  logic                               reset,
   input  ptgt_pkg::cfg_type                  cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ptgt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               q_full,
   output logic                               q_push,
   output ptgt_pkg::job_type                  q_job
);
   import ptgt_pkg::*;

   logic                rec_valid;
   logic [STAMP_W-1:0]  stamp;
   logic [31:0]         ttl;
   logic                accept;
   logic [STAMP_W-1:0]  delta;

   logic [STAMP_W-1:0]  last_stamp_ff, last_stamp_in;
   logic                have_last_ff, have_last_in;
   logic                triggered_ff, triggered_in;
   logic [CNT_W-1:0]    inv_ff, inv_in, dup_ff, dup_in, ooo_ff, ooo_in, gap_ff, gap_in;

   assign rec_valid  = req_tdata[0];
   assign stamp      = req_tdata[64:1];
   assign ttl        = req_tdata[96:65];
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;
   assign delta      = stamp - last_stamp_ff;

   // Classify the request and bump the saturating counters
   always_comb begin
      last_stamp_in = last_stamp_ff;
      have_last_in  = have_last_ff;
      triggered_in  = triggered_ff;
      inv_in        = inv_ff;
      dup_in        = dup_ff;
      ooo_in        = ooo_ff;
      gap_in        = gap_ff;
      q_job         = '0;
      q_job.delta   = delta;
      if (!rec_valid) begin
         inv_in       = (&inv_ff) ? inv_ff : inv_ff + CNT_W'(1);
         q_job.status = ST_INVALID;
      end else begin
         q_job.stamp = stamp;
         if (!have_last_ff) begin
            have_last_in  = 1'b1;
            last_stamp_in = stamp;
            q_job.status  = ST_FIRST;
         end else if (stamp == last_stamp_ff) begin
            dup_in       = (&dup_ff) ? dup_ff : dup_ff + CNT_W'(1);
            q_job.status = ST_DUPLICATE;
         end else if (stamp < last_stamp_ff) begin
            ooo_in       = (&ooo_ff) ? ooo_ff : ooo_ff + CNT_W'(1);
            q_job.status = ST_OUT_OF_ORDER;
         end else begin
            q_job.status  = ST_IN_ORDER;
            last_stamp_in = stamp;
            if (delta > STAMP_W'(cfg.gap_threshold)) begin
               gap_in       = (&gap_ff) ? gap_ff : gap_ff + CNT_W'(1);
               q_job.status = ST_GAP;
            end
         end
         // Latch the trigger once seen
         if (cfg.trig_enable && !triggered_ff && ttl[cfg.trig_bit]) begin
            triggered_in = 1'b1;
         end
         q_job.dispatch = !cfg.trig_enable || triggered_in;
      end
      q_job.invalid_total      = inv_in;
      q_job.duplicate_total    = dup_in;
      q_job.out_of_order_total = ooo_in;
      q_job.gap_total          = gap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
         have_last_ff  <= 1'b0;
         triggered_ff  <= 1'b0;
         inv_ff        <= '0;
         dup_ff        <= '0;
         ooo_ff        <= '0;
         gap_ff        <= '0;
      end else if (accept) begin
         last_stamp_ff <= last_stamp_in;
         have_last_ff  <= have_last_in;
         triggered_ff  <= triggered_in;
         inv_ff        <= inv_in;
         dup_ff        <= dup_in;
         ooo_ff        <= ooo_in;
         gap_ff        <= gap_in;
      end
   end

endmodule

[rtl/core/ptgt_queue.sv]
module ptgt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptgt_pkg::job_type push_job,
   input  logic              pop,
   output ptgt_pkg::job_type pop_job,
   output logic              empty,
   output logic              full
);
   import ptgt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign pop_job = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/ptgt_back.sv]
`include "packet_timestamp_gap_tracker_defines.svh"

module ptgt_back #(
   parameter int MAX_BATCH = ptgt_pkg::MAX_BATCH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ptgt_pkg::cfg_type                 cfg,
   input  ptgt_pkg::job_type                 q_job,
   input  logic                              q_empty,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ptgt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import ptgt_pkg::*;

   localparam int BS_W   = $clog2(MAX_BATCH + 1);
   localparam int PROD_W = FILL_W + BS_W;
   localparam logic [STAMP_W-1:0] U64MAX = '1;

   back_state_type          state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [STAMP_W-1:0]      missed_sum_ff, missed_sum_in;
   logic [STAMP_W-1:0]      filled_sum_ff, filled_sum_in;
   logic [STAMP_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]        missed_now_ff, missed_now_in;
   logic [BS_W-1:0]         batch_fill_ff, batch_fill_in;
   logic                    emit_ff, emit_in, bstart_ff, bstart_in, bend_ff, bend_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [STAMP_W-1:0]      lag_ff, lag_in;
   logic [FILL_W-1:0]       k_ff, k_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [DIV_D_W-1:0]      period_eff;
   logic [BS_W-1:0]         bs;
   logic [BS_W-1:0]         next_fill;
   logic [STAMP_W-1:0]      quot_lo;
   logic                    round_up;
   logic [STAMP_W:0]        sum_wide;
   logic                    rsp_has_fill;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   ptgt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Effective period and batch size
   always_comb begin
      period_eff = (cfg.period == '0) ? DIV_D_W'(1) : DIV_D_W'(cfg.period);
      if (cfg.batch_len == '0) begin
         bs = BS_W'(1);
      end else if (32'(cfg.batch_len) > 32'(MAX_BATCH)) begin
         bs = BS_W'(MAX_BATCH);
      end else begin
         bs = BS_W'(cfg.batch_len);
      end
   end

   assign next_fill = batch_fill_ff + BS_W'(1);
   assign quot_lo   = div_rsp.quot[STAMP_W-1:0];
   assign round_up  = ({div_rsp.rem, 1'b0} >= {1'b0, period_eff});
   assign sum_wide  = {1'b0, missed_sum_ff} + {1'b0, n_ff};

   // Sequence one request through gap count, batching and fill
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      missed_sum_in = missed_sum_ff;
      filled_sum_in = filled_sum_ff;
      n_in          = n_ff;
      missed_now_in = missed_now_ff;
      batch_fill_in = batch_fill_ff;
      emit_in       = emit_ff;
      bstart_in     = bstart_ff;
      bend_in       = bend_ff;
      idx_in        = idx_ff;
      lag_in        = lag_ff;
      k_in          = k_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      div_req       = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop         = 1'b1;
               job_in        = q_job;
               missed_now_in = '0;
               emit_in       = 1'b0;
               bstart_in     = 1'b0;
               bend_in       = 1'b0;
               idx_in        = '0;
               k_in          = '0;
               if (q_job.status == ST_GAP) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {q_job.delta, 8'b0};
                  div_req.divisor  = period_eff;
                  state_in         = BK_MISS_DIV;
               end else begin
                  state_in = BK_BATCH;
               end
            end
         end
         BK_MISS_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quot[DIV_N_W-1:STAMP_W] != '0) begin
                  n_in = U64MAX;
               end else if (round_up) begin
                  n_in = (quot_lo == U64MAX) ? U64MAX - STAMP_W'(1) : quot_lo;
               end else begin
                  n_in = (quot_lo == '0) ? '0 : quot_lo - STAMP_W'(1);
               end
               missed_now_in = (n_in[STAMP_W-1:CNT_W] != '0) ? '1 : n_in[CNT_W-1:0];
               state_in      = BK_MISS_SUM;
            end
         end
         BK_MISS_SUM: begin
            missed_sum_in = sum_wide[STAMP_W] ? U64MAX : sum_wide[STAMP_W-1:0];
            state_in      = BK_BATCH;
         end
         BK_BATCH: begin
            state_in = BK_OUT;
            if (job_ff.dispatch) begin
               emit_in       = 1'b1;
               bstart_in     = (batch_fill_ff == '0);
               idx_in        = IDX_W'(batch_fill_ff);
               batch_fill_in = next_fill;
               if (next_fill >= bs) begin
                  bend_in       = 1'b1;
                  batch_fill_in = '0;
                  if (cfg.fill_mode == FILL_ASAP || cfg.fill_mode == FILL_DISTRIBUTED) begin
                     lag_in   = (missed_sum_ff > filled_sum_ff) ?
                                missed_sum_ff - filled_sum_ff : '0;
                     state_in = BK_LAG_SEL;
                  end
               end
            end
         end
         BK_LAG_SEL: begin
            if (cfg.fill_mode == FILL_DISTRIBUTED) begin
               k_in     = (lag_ff >= STAMP_W'(bs)) ? FILL_W'(1) : '0;
               state_in = BK_FILL_MUL;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {8'b0, lag_ff};
               div_req.divisor  = DIV_D_W'(bs);
               state_in         = BK_LAG_DIV;
            end
         end
         BK_LAG_DIV: begin
            if (div_rsp.done) begin
               k_in     = (div_rsp.quot[DIV_N_W-1:FILL_W] != '0) ? '1 :
                          div_rsp.quot[FILL_W-1:0];
               state_in = BK_FILL_MUL;
            end
         end
         BK_FILL_MUL: begin
            prod_in  = PROD_W'(k_ff) * PROD_W'(bs);
            state_in = BK_FILL_ADD;
         end
         BK_FILL_ADD: begin
            filled_sum_in = filled_sum_ff + STAMP_W'(prod_ff);
            state_in      = BK_OUT;
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b0, job_ff.gap_total, job_ff.out_of_order_total,
                               job_ff.duplicate_total, job_ff.invalid_total,
                               job_ff.stamp, k_ff, bend_ff, bstart_ff, idx_ff,
                               emit_ff, missed_now_ff, job_ff.status};
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         missed_sum_ff <= '0;
         filled_sum_ff <= '0;
         batch_fill_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         missed_sum_ff <= missed_sum_in;
         filled_sum_ff <= filled_sum_in;
         batch_fill_ff <= batch_fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      job_ff        <= job_in;
      n_ff          <= n_in;
      missed_now_ff <= missed_now_in;
      emit_ff       <= emit_in;
      bstart_ff     <= bstart_in;
      bend_ff       <= bend_in;
      idx_ff        <= idx_in;
      lag_ff        <= lag_in;
      k_ff          <= k_in;
      prod_ff       <= prod_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_has_fill = rsp_valid_ff && (rsp_data_ff[61:46] != '0);

   `PTGT_ASSERT_ALWAYS(a_fill_le_miss, clock, reset, filled_sum_ff <= missed_sum_ff, "fill > missed")
   `PTGT_ASSERT_IMPLY(a_fill_at_end, clock, reset, rsp_has_fill, rsp_data_ff[45], "fill off batch end")
   `PTGT_ASSERT_ALWAYS(a_fill_range, clock, reset, batch_fill_ff < BS_W'(MAX_BATCH), "fill range")

endmodule
